[design/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// sacl_pkg
// shared sizes, codes and types of the set-associative tag cache
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

	// cache geometry
	localparam int SET_COUNT  = 64;
	localparam int NUM_WAYS   = 4;
	localparam int LINE_BYTES = 64;

	// address split
	localparam int ADDR_W = 48;
	localparam int OFFS_W = $clog2(LINE_BYTES);
	localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int SET_LO = OFFS_W;
	localparam int TAG_LO = OFFS_W + $clog2(SET_COUNT);
	localparam int TAG_W  = ADDR_W - TAG_LO;
	localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	// ram row: tags of all ways, dirty bits of all ways on top
	localparam int ROW_W  = (TAG_W + 1) * NUM_WAYS;

	// statistics
	localparam int CNT_W = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// stream word widths
	localparam int S_TDATA_W = ((ADDR_W + 7) / 8) * 8;
	localparam int S_TUSER_W = 1;
	localparam int M_FIELD_W = 3 + 4 * CNT_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK   = 4'd1;

	// codes
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;
	localparam logic REPL_LRU  = 1'b0;
	localparam logic REPL_FIFO = 1'b1;
	localparam logic WB_OFF    = 1'b0;
	localparam logic WB_ON     = 1'b1;

	typedef logic [TAG_W-1:0]    tag_t;
	typedef tag_t [NUM_WAYS-1:0] tag_row_t;
	typedef logic [NUM_WAYS-1:0] way_bits_t;
	typedef logic [SET_W-1:0]    set_idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	// outcome of one lookup
	typedef struct packed {
		logic hit;
		logic mem_write;
	} lookup_t;

	// the four running totals
	typedef struct packed {
		cnt_t writes;
		cnt_t reads;
		cnt_t misses;
		cnt_t hits;
	} stats_t;

endpackage

`default_nettype wire

[design/sacl_ram.sv]
// ----------------------------------------------------------------------------
// sacl_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/sacl_update.sv]
// ----------------------------------------------------------------------------
// sacl_update
// tag match and replacement-order update of one set
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_update (
	input  wire sacl_pkg::tag_t      tag,
	input  wire logic                is_write,
	input  wire logic                replace_mode,
	input  wire logic                write_back,
	input  wire sacl_pkg::tag_row_t  old_tags,
	input  wire sacl_pkg::way_bits_t old_valid,
	input  wire sacl_pkg::way_bits_t old_dirty,
	output sacl_pkg::tag_row_t       new_tags,
	output sacl_pkg::way_bits_t      new_valid,
	output sacl_pkg::way_bits_t      new_dirty,
	output sacl_pkg::lookup_t        result
);

	import sacl_pkg::*;

	way_bits_t        match;
	logic             hit;
	logic [WAY_W-1:0] hit_way;
	logic             lru_hit;
	logic             hit_dirty;
	logic             victim_dirty;

	// first valid way with a matching tag
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int i = 0; i < NUM_WAYS; i++) begin
			match[i] = old_valid[i] && (old_tags[i] == tag);
		end
		for (int i = NUM_WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_way = WAY_W'(i);
			end
		end
	end

	assign lru_hit      = hit && (replace_mode == REPL_LRU);
	assign hit_dirty    = old_dirty[hit_way];
	assign victim_dirty = old_valid[NUM_WAYS-1] && old_dirty[NUM_WAYS-1];

	// ways at or above the hit move down one on an lru hit, all ways on a miss
	always_comb begin
		new_tags  = old_tags;
		new_valid = old_valid;
		new_dirty = old_dirty;
		if (hit && !lru_hit) begin
			new_dirty[hit_way] = hit_dirty | is_write;
		end else begin
			for (int i = 1; i < NUM_WAYS; i++) begin
				if (!hit || (WAY_W'(i) <= hit_way)) begin
					new_tags[i]  = old_tags[i-1];
					new_valid[i] = old_valid[i-1];
					new_dirty[i] = old_dirty[i-1];
				end
			end
			new_tags[0]  = tag;
			new_valid[0] = 1'b1;
			new_dirty[0] = hit ? (hit_dirty | is_write) : is_write;
		end
	end

	always_comb begin
		result.hit = hit;
		if (hit) begin
			result.mem_write = (is_write == CMD_WRITE) && (write_back == WB_OFF);
		end else begin
			result.mem_write = (write_back == WB_ON) && victim_dirty;
		end
	end

endmodule

`default_nettype wire

[design/sacl_stats.sv]
// ----------------------------------------------------------------------------
// sacl_stats
// saturating hit, miss, fill and memory-write totals
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_stats (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              update,
	input  wire sacl_pkg::lookup_t result,
	output sacl_pkg::stats_t       totals_next
);

	import sacl_pkg::*;

	stats_t totals_q;

	function automatic cnt_t sat_inc(input cnt_t v, input logic en);
		sat_inc = (en && (v != CNT_MAX)) ? v + cnt_t'(1) : v;
	endfunction

	// totals after the access now being retired
	always_comb begin
		totals_next.hits   = sat_inc(totals_q.hits, result.hit);
		totals_next.misses = sat_inc(totals_q.misses, !result.hit);
		totals_next.reads  = sat_inc(totals_q.reads, !result.hit);
		totals_next.writes = sat_inc(totals_q.writes, result.mem_write);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			totals_q <= '0;
		end else if (update) begin
			totals_q <= totals_next;
		end
	end

endmodule

`default_nettype wire

[design/set_assoc_cache_lru_fifo_core.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_fifo_core
// tag-only set-associative cache with lru or fifo replacement and counters
// ----------------------------------------------------------------------------
// flow: an accepted access has its set read into the lookup stage, then the
// set is updated and its result word is written into the result register
// throughput: one access per cycle while the result side does not stall, set by
// the single read port of the row ram and the set update with forwarding of the
// previous row; input is held off while a configuration word is offered
// reset: all lines invalid, totals zero, lru, write-back mode;
// no clearing pass, the block accepts words from the first cycle after reset
`default_nettype none

module set_assoc_cache_lru_fifo_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// access stream
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [sacl_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // address
	input  wire logic [sacl_pkg::S_TUSER_W-1:0]     s_axis_tuser,  // command
	// result stream
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// hit, mem_read, mem_write, hit_count, miss_count, read_count, write_count
	output logic [sacl_pkg::M_TDATA_W-1:0]          m_axis_tdata,
	// configuration writes
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import sacl_pkg::*;

	// configuration registers
	logic replace_mode_q;
	logic write_back_q;

	// handshakes
	logic in_acc;
	logic s1_fire;

	// lookup stage
	logic      valid_s1;
	logic      cmd_s1;
	tag_t      tag_s1;
	set_idx_t  set_s1;
	logic      fwd_s1;        // row of this set was written as it was read
	way_bits_t way_valid_s1;  // valid bits of the set, taken with the access

	// valid per line, cleared at reset
	way_bits_t valid_q [SET_COUNT];

	// last written row, for forwarding
	logic [ROW_W-1:0] wr_row_q;

	// ram and update wiring
	logic [ROW_W-1:0] ram_rdata;
	logic [ROW_W-1:0] old_row;
	logic [ROW_W-1:0] new_row;
	tag_row_t         old_tags;
	way_bits_t        old_dirty;
	tag_row_t         new_tags;
	way_bits_t        new_valid;
	way_bits_t        new_dirty;
	lookup_t          lookup;
	stats_t           totals_next;

	// output register
	logic                 m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;

	tag_t     in_tag;
	set_idx_t in_set;

	assign in_tag = s_axis_tdata[TAG_LO +: TAG_W];
	assign in_set = (SET_COUNT > 1) ? set_idx_t'(s_axis_tdata[SET_LO +: SET_W]) : '0;

	// the lookup stage retires when the output register is free or drained
	assign s1_fire       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = (!valid_s1 || s1_fire) && !cfg_valid;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// config is only taken with no access in the lookup stage
	assign cfg_ready = !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_mode_q <= REPL_LRU;
			write_back_q   <= WB_ON;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REPLACE_MODE: replace_mode_q <= cfg_data[0];
				CFG_WRITE_BACK:   write_back_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// row store: tags and dirty bits of all ways per set
	sacl_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SET_COUNT)
	) u_tag_ram (
		.clk  (clk),
		.we   (s1_fire),
		.waddr(set_s1),
		.wdata(new_row),
		.re   (in_acc),
		.raddr(in_set),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload, held while the stage stalls
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= s_axis_tuser[0];
			tag_s1 <= in_tag;
			set_s1 <= in_set;
			// a write to the same set on this edge is missed by the ram read
			fwd_s1 <= s1_fire && (set_s1 == in_set);
			way_valid_s1 <= (s1_fire && (set_s1 == in_set)) ? new_valid : valid_q[in_set];
		end
	end

	assign old_row   = fwd_s1 ? wr_row_q : ram_rdata;
	assign old_tags  = old_row[$bits(tag_row_t)-1:0];
	assign old_dirty = old_row[ROW_W-1 -: NUM_WAYS];
	assign new_row   = {new_dirty, new_tags};

	sacl_update u_update (
		.tag         (tag_s1),
		.is_write    (cmd_s1),
		.replace_mode(replace_mode_q),
		.write_back  (write_back_q),
		.old_tags    (old_tags),
		.old_valid   (way_valid_s1),
		.old_dirty   (old_dirty),
		.new_tags    (new_tags),
		.new_valid   (new_valid),
		.new_dirty   (new_dirty),
		.result      (lookup)
	);

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			wr_row_q <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SET_COUNT; s++) begin
				valid_q[s] <= '0;
			end
		end else if (s1_fire) begin
			valid_q[set_s1] <= new_valid;
		end
	end

	sacl_stats u_stats (
		.clk        (clk),
		.arst_n     (arst_n),
		.update     (s1_fire),
		.result     (lookup),
		.totals_next(totals_next)
	);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			m_data_q <= M_TDATA_W'({totals_next.writes, totals_next.reads,
				totals_next.misses, totals_next.hits,
				lookup.mem_write, !lookup.hit, lookup.hit});
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

[design/sacl_checker.sv]
// ----------------------------------------------------------------------------
// sacl_checker
// port-level checks of the cache result stream
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [sacl_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	import sacl_pkg::*;

	logic hit_f;
	logic rd_f;
	logic wr_f;
	cnt_t hits_f;
	cnt_t misses_f;
	cnt_t reads_f;
	cnt_t writes_f;

	assign hit_f    = m_axis_tdata[0];
	assign rd_f     = m_axis_tdata[1];
	assign wr_f     = m_axis_tdata[2];
	assign hits_f   = m_axis_tdata[3 +: CNT_W];
	assign misses_f = m_axis_tdata[3 + CNT_W +: CNT_W];
	assign reads_f  = m_axis_tdata[3 + 2 * CNT_W +: CNT_W];
	assign writes_f = m_axis_tdata[3 + 3 * CNT_W +: CNT_W];

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// every miss is one fill, both totals saturate together
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (rd_f != hit_f) && (misses_f == reads_f))
		else $error("miss and fill disagree");

	// the flagged event is already in its total
	a_hit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!hit_f || (hits_f != '0)) && (hit_f || (misses_f != '0)))
		else $error("hit or miss not counted");

	a_wr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && wr_f |-> (writes_f != '0))
		else $error("memory write not counted");

endmodule

bind set_assoc_cache_lru_fifo_core sacl_checker u_sacl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

[dv/set_assoc_cache_lru_fifo_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_fifo_core_test
// access streams against a tag-level cache predictor with lru/fifo, wb/wt
// ----------------------------------------------------------------------------
// directed accesses walk empty ways, dirty and clean evictions, lru moves,
// fifo hits and a switch from write-through to write-back; then random
// accesses are aimed at a few hot sets and tags, across several policies,
// with random stalls on both streams and a long hold on the result side

module set_assoc_cache_lru_fifo_core_test;

	import sacl_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int STALL_LIMIT = 4000;  // cycles with no word moving anywhere
	localparam int LONG_HOLD   = 200;   // receiver hold-off in the pressure phase
	localparam int TAG_POOL    = 6;
	localparam int HOT_SETS    = 3;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 96;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [OFFS_W-1:0] offs_t;

	// one expected result word
	typedef struct {
		int   seq;
		logic hit;
		logic mem_read;
		logic mem_write;
		cnt_t hits;
		cnt_t misses;
		cnt_t reads;
		cnt_t writes;
	} access_result_t;

	// tag-level copy of the cache with its own policy registers
	class cache_scoreboard;
		tag_t           line_tag   [SET_COUNT][NUM_WAYS];
		bit             line_valid [SET_COUNT][NUM_WAYS];
		bit             line_dirty [SET_COUNT][NUM_WAYS];
		logic           repl_mode;
		logic           wb_mode;
		cnt_t           hits, misses, fills, mem_writes;
		access_result_t expected_q[$];
		int             accesses;
		int             errors;

		function new();
			foreach (line_valid[s, w]) begin
				line_valid[s][w] = 1'b0;
				line_dirty[s][w] = 1'b0;
			end
			repl_mode  = REPL_LRU;
			wb_mode    = WB_ON;
			hits       = '0;
			misses     = '0;
			fills      = '0;
			mem_writes = '0;
			accesses   = 0;
			errors     = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function cnt_t bump(cnt_t v);
			return (v == CNT_MAX) ? v : v + 1'b1;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_REPLACE_MODE: repl_mode = val[0];
				CFG_WRITE_BACK:   wb_mode   = val[0];
				default: ;  // unknown index, no effect
			endcase
		endfunction

		function void shift_down(set_idx_t s, int from_way);
			for (int i = from_way; i > 0; i--) begin
				line_tag[s][i]   = line_tag[s][i-1];
				line_valid[s][i] = line_valid[s][i-1];
				line_dirty[s][i] = line_dirty[s][i-1];
			end
		endfunction

		function void note_access(logic cmd, addr_t addr);
			set_idx_t       s;
			tag_t           tg;
			bit             found;
			bit             is_wr;
			bit             mw;
			bit             d;
			int             way;
			access_result_t r;
			s     = addr[SET_LO +: SET_W];
			tg    = addr[TAG_LO +: TAG_W];
			is_wr = (cmd == CMD_WRITE);
			found = 1'b0;
			mw    = 1'b0;
			way   = 0;
			for (int i = 0; i < NUM_WAYS; i++) begin
				if (!found && line_valid[s][i] && line_tag[s][i] == tg) begin
					found = 1'b1;
					way   = i;
				end
			end
			if (found) begin
				hits = bump(hits);
				if (is_wr && wb_mode == WB_OFF)
					mw = 1'b1;
				if (repl_mode == REPL_LRU) begin
					d = line_dirty[s][way] | is_wr;
					shift_down(s, way);
					line_tag[s][0]   = tg;
					line_valid[s][0] = 1'b1;
					line_dirty[s][0] = d;
				end else begin
					line_dirty[s][way] = line_dirty[s][way] | is_wr;
				end
			end else begin
				misses = bump(misses);
				fills  = bump(fills);
				// dirty victim only costs a write in write-back mode
				if (wb_mode == WB_ON && line_valid[s][NUM_WAYS-1] && line_dirty[s][NUM_WAYS-1])
					mw = 1'b1;
				shift_down(s, NUM_WAYS - 1);
				line_tag[s][0]   = tg;
				line_valid[s][0] = 1'b1;
				line_dirty[s][0] = is_wr;
			end
			if (mw)
				mem_writes = bump(mem_writes);
			r.seq       = accesses;
			r.hit       = found;
			r.mem_read  = !found;
			r.mem_write = mw;
			r.hits      = hits;
			r.misses    = misses;
			r.reads     = fills;
			r.writes    = mem_writes;
			expected_q.push_back(r);
			accesses++;
		endfunction

		function void compare(int seq, string name, logic [63:0] exp, logic [63:0] act);
			if (exp !== act) begin
				errors++;
				$error("access %0d: %s expected %0d, actual %0d", seq, name, exp, act);
			end
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] word);
			access_result_t r;
			if (expected_q.size() == 0) begin
				errors++;
				$error("result word with no access waiting: %h", word);
				return;
			end
			r = expected_q.pop_front();
			compare(r.seq, "hit", r.hit, word[0]);
			compare(r.seq, "mem_read", r.mem_read, word[1]);
			compare(r.seq, "mem_write", r.mem_write, word[2]);
			compare(r.seq, "hit_count", r.hits, word[3 +: CNT_W]);
			compare(r.seq, "miss_count", r.misses, word[3 + CNT_W +: CNT_W]);
			compare(r.seq, "read_count", r.reads, word[3 + 2*CNT_W +: CNT_W]);
			compare(r.seq, "write_count", r.writes, word[3 + 3*CNT_W +: CNT_W]);
			compare(r.seq, "padding", 0, word[M_TDATA_W-1:M_FIELD_W]);
		endfunction

		function void close();
			if (expected_q.size() != 0) begin
				errors += expected_q.size();
				$error("%0d result words never arrived", expected_q.size());
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;   // address
	logic [S_TUSER_W-1:0]  s_axis_tuser;   // command
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// hit, mem_read, mem_write, hit_count, miss_count, read_count, write_count
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cache_scoreboard sb;

	// stall controls shared by the sender, the receiver and the sequence
	bit tx_gaps_on;
	bit tx_burst;
	bit rx_stalls_on;
	bit long_hold_req;
	int idle_cycles;
	int policy_count;

	tag_t     tag_pool [TAG_POOL];
	set_idx_t hot_set  [HOT_SETS];

	set_assoc_cache_lru_fifo_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// every word that moves is seen here; accesses are noted before results
	// are checked so a combinational path from access to result would still line up
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_access(s_axis_tuser[0], s_axis_tdata[ADDR_W-1:0]);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
		end
	end

	// watchdog: too long with no word moved on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles with no word moved", idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random hold-offs, free-running stretches, one long hold
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			if (long_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		if (!tx_gaps_on || !tx_burst)
			return 0;
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 15);
		return 0;
	endfunction

	function automatic addr_t line_addr(tag_t tg, set_idx_t s, offs_t off);
		return {tg, s, off};
	endfunction

	// one access word; valid stays up into the next word when there is no gap
	task automatic send_access(input logic cmd, input addr_t addr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= addr;
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// mostly hot sets and a small tag pool so lines hit and get evicted,
	// now and then a fully random address
	task automatic random_access();
		logic  cmd;
		addr_t addr;
		cmd = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0)
			addr = ADDR_W'({$urandom, $urandom});
		else
			addr = line_addr(tag_pool[$urandom_range(0, TAG_POOL-1)],
			                 hot_set[$urandom_range(0, HOT_SETS-1)], offs_t'($urandom));
		send_access(cmd, addr);
	endtask

	// drop valid and wait until every outstanding result word is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	// both policy registers, then a write to an index that does not exist
	task automatic set_policy(input logic mode, input logic wb);
		logic [CFG_IDX_W-1:0]  idx [3];
		logic [CFG_DATA_W-1:0] val [3];
		idx[0] = CFG_REPLACE_MODE;
		val[0] = mode;
		idx[1] = CFG_WRITE_BACK;
		val[1] = wb;
		idx[2] = CFG_IDX_W'($urandom_range(2, (1 << CFG_IDX_W) - 1));
		val[2] = CFG_DATA_W'($urandom);
		drain();
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		policy_count++;
	endtask

	task automatic new_hot_lines();
		foreach (tag_pool[i])
			tag_pool[i] = TAG_W'({$urandom, $urandom});
		foreach (hot_set[i])
			hot_set[i] = set_idx_t'($urandom_range(0, SET_COUNT - 1));
	endtask

	initial begin
		logic phase_mode [PHASES];
		logic phase_wb   [PHASES];
		sb            = new();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		tx_gaps_on    = 1'b1;
		tx_burst      = 1'b1;
		rx_stalls_on  = 1'b1;
		long_hold_req = 1'b0;
		idle_cycles   = 0;
		policy_count  = 1;  // reset policy counts as the first setting
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset policy: lru, write-back
		// address extremes, miss into empty ways, then hits on them
		send_access(CMD_READ,  '0);
		send_access(CMD_WRITE, '1);
		send_access(CMD_READ,  '1);
		send_access(CMD_WRITE, '0);
		// fill set 5, lru move of a dirty line, clean then dirty evictions
		send_access(CMD_WRITE, line_addr(tag_t'(1), set_idx_t'(5), offs_t'(0)));
		send_access(CMD_READ,  line_addr(tag_t'(2), set_idx_t'(5), '1));
		send_access(CMD_READ,  line_addr(tag_t'(3), set_idx_t'(5), offs_t'(7)));
		send_access(CMD_READ,  line_addr(tag_t'(4), set_idx_t'(5), offs_t'(9)));
		send_access(CMD_READ,  line_addr(tag_t'(1), set_idx_t'(5), offs_t'(3)));
		send_access(CMD_READ,  line_addr(tag_t'(5), set_idx_t'(5), offs_t'(0)));
		send_access(CMD_READ,  line_addr(tag_t'(6), set_idx_t'(5), offs_t'(0)));
		send_access(CMD_READ,  line_addr(tag_t'(7), set_idx_t'(5), offs_t'(0)));
		send_access(CMD_READ,  line_addr(tag_t'(8), set_idx_t'(5), offs_t'(0)));

		// fifo, write-through: write miss stays quiet, write hit writes,
		// a fifo hit leaves the oldest line where it is
		set_policy(REPL_FIFO, WB_OFF);
		send_access(CMD_WRITE, line_addr('1, set_idx_t'(9), offs_t'(1)));
		send_access(CMD_WRITE, line_addr('1, set_idx_t'(9), offs_t'(2)));
		send_access(CMD_READ,  line_addr(tag_t'(2), set_idx_t'(9), offs_t'(0)));
		send_access(CMD_READ,  line_addr('1, set_idx_t'(9), offs_t'(0)));
		send_access(CMD_READ,  line_addr(tag_t'(3), set_idx_t'(9), offs_t'(0)));

		// back to write-back: the line dirtied under write-through now costs
		// a memory write when it falls out
		set_policy(REPL_FIFO, WB_ON);
		send_access(CMD_READ,  line_addr(tag_t'(4), set_idx_t'(9), offs_t'(0)));
		send_access(CMD_READ,  line_addr(tag_t'(5), set_idx_t'(9), offs_t'(0)));
		send_access(CMD_WRITE, line_addr(tag_t'(6), '1, offs_t'(0)));

		phase_mode[0] = REPL_LRU;  phase_wb[0] = WB_ON;
		phase_mode[1] = REPL_FIFO; phase_wb[1] = WB_OFF;
		phase_mode[2] = REPL_LRU;  phase_wb[2] = WB_OFF;
		phase_mode[3] = REPL_FIFO; phase_wb[3] = WB_ON;
		phase_mode[4] = REPL_LRU;  phase_wb[4] = WB_ON;

		for (int p = 0; p < PHASES; p++) begin
			set_policy(phase_mode[p], phase_wb[p]);
			new_hot_lines();
			if (p == PHASES - 1) begin
				// closing stretch runs at full rate on both sides
				tx_gaps_on   = 1'b0;
				rx_stalls_on = 1'b0;
			end
			if (p == 2) begin
				// result side holds off while accesses keep coming
				long_hold_req = 1'b1;
				tx_burst      = 1'b0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 24 == 0 && !(p == 2 && n == 0))
					tx_burst = $urandom_range(0, 1);
				random_access();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		sb.close();

		$display("covered %0d accesses: %0d hits, %0d misses, %0d memory writes",
		         sb.accesses, sb.hits, sb.misses, sb.mem_writes);
		$display("over %0d replacement/write policy settings with stalls on both streams",
		         policy_count);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
